>>> rtl/ppi_pkg.sv
package ppi_pkg;

    localparam logic [7:0] CTRL_RESET   = 8'h9B;
    localparam int unsigned CTRL_MODESET_BIT = 7;
    localparam int unsigned CTRL_A_IN_BIT    = 4;
    localparam int unsigned CTRL_CHI_IN_BIT  = 3;
    localparam int unsigned CTRL_B_IN_BIT    = 1;
    localparam int unsigned CTRL_CLO_IN_BIT  = 0;

    localparam logic [3:0] JUMPERS_RESET = 4'hF;
    localparam logic [7:0] NIBBLE_HI     = 8'hF0;
    localparam logic [7:0] NIBBLE_LO     = 8'h0F;

    typedef enum logic [1:0] {
        SEL_PORT_A  = 2'd0,
        SEL_PORT_B  = 2'd1,
        SEL_PORT_C  = 2'd2,
        SEL_CONTROL = 2'd3
    } port_sel_t;

    typedef enum logic {
        ACT_READ  = 1'b0,
        ACT_WRITE = 1'b1
    } action_t;

    typedef struct packed {
        action_t   action;
        port_sel_t port_select;
        logic [7:0] write_data;
        logic [7:0] port_a_pins;
        logic       vsync_level;
        logic       tape_in;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] port_a_out;
        logic [7:0] port_b_out;
        logic [7:0] port_c_pins;
        logic [3:0] keyboard_row;
    } result_t;

endpackage

>>> rtl/ppi_core.sv
module ppi_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  ppi_pkg::req_t    req,
    input  logic             cfg_we,
    input  logic [3:0]       cfg_wdata,
    output logic [3:0]       jumpers,
    output ppi_pkg::result_t result
);
    import ppi_pkg::*;

    logic [7:0] ctrl_reg;
    logic [7:0] latch_a_reg;
    logic [7:0] latch_b_reg;
    logic [7:0] latch_c_reg;
    logic [3:0] jumpers_reg;

    logic [7:0] ctrl_next;
    logic [7:0] latch_a_next;
    logic [7:0] latch_b_next;
    logic [7:0] latch_c_next;
    logic [7:0] rd_value;
    logic [7:0] bit_mask;
    logic [7:0] c_cur_vis;
    logic [7:0] c_next_vis;
    logic [7:0] b_in_value;

    // visible port C: only halves set as output
    always_comb
    begin
        c_cur_vis = (ctrl_reg[CTRL_CHI_IN_BIT] ? 8'h00 : (latch_c_reg & NIBBLE_HI))
                  | (ctrl_reg[CTRL_CLO_IN_BIT] ? 8'h00 : (latch_c_reg & NIBBLE_LO));
        b_in_value = {req.tape_in, 1'b0, 1'b0, jumpers_reg, req.vsync_level};
        bit_mask   = 8'h01 << req.write_data[3:1];
    end

    always_comb
    begin
        ctrl_next    = ctrl_reg;
        latch_a_next = latch_a_reg;
        latch_b_next = latch_b_reg;
        latch_c_next = latch_c_reg;
        rd_value     = 8'h00;
        if (req.action == ACT_WRITE)
        begin
            unique case (req.port_select)
                SEL_PORT_A:
                begin
                    if (!ctrl_reg[CTRL_A_IN_BIT])
                        latch_a_next = req.write_data;
                end
                SEL_PORT_B:
                begin
                    if (!ctrl_reg[CTRL_B_IN_BIT])
                        latch_b_next = req.write_data;
                end
                SEL_PORT_C:
                begin
                    latch_c_next = req.write_data;
                end
                SEL_CONTROL:
                begin
                    if (req.write_data[CTRL_MODESET_BIT])
                    begin
                        ctrl_next    = req.write_data;
                        latch_a_next = 8'h00;
                        latch_b_next = 8'h00;
                        latch_c_next = 8'h00;
                    end
                    else if (req.write_data[0])
                    begin
                        latch_c_next = latch_c_reg | bit_mask;
                    end
                    else
                    begin
                        latch_c_next = latch_c_reg & ~bit_mask;
                    end
                end
                default:
                begin
                    ctrl_next = ctrl_reg;
                end
            endcase
        end
        else
        begin
            unique case (req.port_select)
                SEL_PORT_A:  rd_value = ctrl_reg[CTRL_A_IN_BIT] ? req.port_a_pins : latch_a_reg;
                SEL_PORT_B:  rd_value = ctrl_reg[CTRL_B_IN_BIT] ? b_in_value : latch_b_reg;
                SEL_PORT_C:  rd_value = c_cur_vis;
                SEL_CONTROL: rd_value = ctrl_reg;
                default:     rd_value = 8'h00;
            endcase
        end
    end

    always_comb
    begin
        c_next_vis = (ctrl_next[CTRL_CHI_IN_BIT] ? 8'h00 : (latch_c_next & NIBBLE_HI))
                   | (ctrl_next[CTRL_CLO_IN_BIT] ? 8'h00 : (latch_c_next & NIBBLE_LO));
        result.read_data    = rd_value;
        result.port_a_out   = latch_a_next;
        result.port_b_out   = latch_b_next;
        result.port_c_pins  = c_next_vis;
        result.keyboard_row = c_next_vis[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg    <= CTRL_RESET;
            latch_a_reg <= 8'h00;
            latch_b_reg <= 8'h00;
            latch_c_reg <= 8'h00;
        end
        else if (accept)
        begin
            ctrl_reg    <= ctrl_next;
            latch_a_reg <= latch_a_next;
            latch_b_reg <= latch_b_next;
            latch_c_reg <= latch_c_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            jumpers_reg <= JUMPERS_RESET;
        else if (cfg_we)
            jumpers_reg <= cfg_wdata;
    end

    assign jumpers = jumpers_reg;

endmodule

>>> rtl/parallel_port_interface_mode0.sv
// Mode-0 three-port parallel interface (A, B, C plus control word). Each request
// is one bus access: a read or write at one of four addresses, carried with the
// current port A pins, vsync and tape levels. The result shows the read byte
// (0 on writes) and the port latches after the access. One request is taken
// every clock cycle while in_stall is low: the decode, latch update and result
// forming sit in a single combinational pass from the port state registers to
// the result (or skid) register. A two-entry output (result register plus skid
// register) lets a request enter while the previous result waits; in_stall
// rises only when both entries are full. The single APB register, hit at any
// address, holds the 4 port B jumper bits (reset 0xF).
module parallel_port_interface_mode0 (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [1:0]  port_select,
    input  logic [7:0]  write_data,
    input  logic [7:0]  port_a_pins,
    input  logic        vsync_level,
    input  logic        tape_in,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic [7:0]  port_a_out,
    output logic [7:0]  port_b_out,
    output logic [7:0]  port_c_pins,
    output logic [3:0]  keyboard_row,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ppi_pkg::*;

    req_t    req;
    result_t core_result;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    accept;
    logic    take;
    logic    cfg_we;
    logic [3:0] jumpers;

    // gather the request fields
    always_comb
    begin
        req.action      = action_t'(action);
        req.port_select = port_sel_t'(port_select);
        req.write_data  = write_data;
        req.port_a_pins = port_a_pins;
        req.vsync_level = vsync_level;
        req.tape_in     = tape_in;
    end

    // stall only when the skid entry is occupied
    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign take     = out_valid_reg && !out_stall;

    // single register: any address in the word hits it
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[1:0] == 2'd0 || paddr != 2'd0);
    assign prdata = {28'd0, jumpers};

    ppi_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (pwdata[3:0]),
        .jumpers   (jumpers),
        .result    (core_result)
    );

    // valid flags of the result and skid entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            // advance skid into the result slot, or refill from the core
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
    end

    // result payloads: no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= core_result;
        end
        else if (accept)
        begin
            if (out_valid_reg)
                skid_reg <= core_result;
            else
                out_reg <= core_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = out_reg.read_data;
    assign port_a_out   = out_reg.port_a_out;
    assign port_b_out   = out_reg.port_b_out;
    assign port_c_pins  = out_reg.port_c_pins;
    assign keyboard_row = out_reg.keyboard_row;

endmodule
